@@ design/apg_pkg.sv @@
package apg_pkg;

    typedef logic [6:0] t_note;
    typedef logic [7:0] t_step;
    typedef logic [7:0] t_code;
    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_chan;

    typedef logic [7:0][7:0] t_step_vec;

    typedef struct packed {
        logic [3:0][6:0] played;
        logic [3:0][6:0] sorted;
        logic [2:0]      count;
        t_mode           mode;
    } t_chord;

    localparam t_mode MODE_SILENT = 2'd3;
    localparam t_chan LAST_CHAN   = 2'd3;

    localparam logic [1:0] OFS_NONE  = 2'd0;
    localparam logic [1:0] OFS_THIRD = 2'd1;
    localparam logic [1:0] OFS_FIFTH = 2'd2;

    localparam t_step THIRD_STEP = 8'd4;
    localparam t_step FIFTH_STEP = 8'd7;

    localparam t_code RS = 8'h00;
    localparam t_code PA = 8'h80;
    localparam t_code PB = 8'h81;
    localparam t_code PC = 8'h82;
    localparam t_code PD = 8'h83;
    localparam t_code SA = 8'h84;
    localparam t_code SB = 8'h85;
    localparam t_code SC = 8'h86;
    localparam t_code SD = 8'h87;
    localparam t_code A4 = 8'h90;
    localparam t_code B4 = 8'h91;
    localparam t_code A7 = 8'hA0;

    // [note count - 1][mode][channel][step]
    localparam t_code PAT_TAB [4][3][4][8] = '{
        '{
            '{ '{PA,RS,RS,RS,RS,RS,RS,RS}, '{PA,A4,RS,RS,RS,RS,RS,RS},
               '{PA,A4,A7,RS,RS,RS,RS,RS}, '{A7,A4,PA,RS,RS,RS,RS,RS} },
            '{ '{PA,A4,A7,A4,RS,RS,RS,RS}, '{A7,A4,PA,A4,RS,RS,RS,RS},
               '{PA,A7,A4,A7,RS,RS,RS,RS}, '{A4,A7,PA,A7,RS,RS,RS,RS} },
            '{ '{PA,A4,A7,A7,A4,PA,RS,RS}, '{A7,A4,PA,PA,A4,A7,RS,RS},
               '{PA,A7,A4,A4,A7,PA,RS,RS}, '{A4,A7,PA,PA,A7,A4,RS,RS} }
        },
        '{
            '{ '{PA,PB,RS,RS,RS,RS,RS,RS}, '{PA,PA,PB,PB,RS,RS,RS,RS},
               '{PA,A4,PB,B4,RS,RS,RS,RS}, '{B4,PB,A4,PA,RS,RS,RS,RS} },
            '{ '{PA,A4,PB,B4,PB,A4,RS,RS}, '{B4,PB,A4,PA,A4,PB,RS,RS},
               '{PA,PB,A4,B4,A4,PB,RS,RS}, '{B4,A4,PB,PA,PB,A4,RS,RS} },
            '{ '{PA,A4,PB,B4,B4,PB,A4,PA}, '{B4,PB,A4,PA,PA,A4,PB,B4},
               '{PA,PB,A4,B4,B4,A4,PB,PA}, '{B4,A4,PB,PA,PA,PB,A4,B4} }
        },
        '{
            '{ '{SA,SB,SC,RS,RS,RS,RS,RS}, '{SC,SB,SA,RS,RS,RS,RS,RS},
               '{PA,PB,PC,RS,RS,RS,RS,RS}, '{PC,PB,PA,RS,RS,RS,RS,RS} },
            '{ '{SA,SB,SC,SB,RS,RS,RS,RS}, '{SC,SB,SA,SB,RS,RS,RS,RS},
               '{PA,PB,PC,PB,RS,RS,RS,RS}, '{PC,PB,PA,PB,RS,RS,RS,RS} },
            '{ '{SA,SB,SC,SC,SB,SA,RS,RS}, '{SC,SB,SA,SA,SB,SC,RS,RS},
               '{PA,PB,PC,PC,PB,PA,RS,RS}, '{PC,PB,PA,PA,PB,PC,RS,RS} }
        },
        '{
            '{ '{SA,SB,SC,SD,RS,RS,RS,RS}, '{SD,SC,SB,SA,RS,RS,RS,RS},
               '{PA,PB,PC,PD,RS,RS,RS,RS}, '{PD,PC,PB,PA,RS,RS,RS,RS} },
            '{ '{SA,SB,SC,SD,SC,SB,RS,RS}, '{SD,SC,SB,SA,SB,SC,RS,RS},
               '{PA,PB,PC,PD,PC,PB,RS,RS}, '{PD,PC,PB,PA,PB,PC,RS,RS} },
            '{ '{SA,SB,SC,SD,SD,SC,SB,SA}, '{SD,SC,SB,SA,SA,SB,SC,SD},
               '{PA,PB,PC,PD,PD,PC,PB,PA}, '{PD,PC,PB,PA,PA,PB,PC,PD} }
        }
    };

endpackage

@@ design/apg_chord_if.sv @@
interface apg_chord_if;
    logic          valid;
    logic          ready;
    apg_pkg::t_note slot_one_note;
    apg_pkg::t_note slot_two_note;
    apg_pkg::t_note slot_three_note;
    apg_pkg::t_note slot_four_note;

    modport source (
        output valid, slot_one_note, slot_two_note, slot_three_note, slot_four_note,
        input  ready
    );
    modport sink (
        input  valid, slot_one_note, slot_two_note, slot_three_note, slot_four_note,
        output ready
    );
endinterface

@@ design/apg_pattern_if.sv @@
interface apg_pattern_if;
    logic           valid;
    logic           ready;
    apg_pkg::t_chan channel;
    apg_pkg::t_step step_zero;
    apg_pkg::t_step step_one;
    apg_pkg::t_step step_two;
    apg_pkg::t_step step_three;
    apg_pkg::t_step step_four;
    apg_pkg::t_step step_five;
    apg_pkg::t_step step_six;
    apg_pkg::t_step step_seven;
    logic           last;

    modport source (
        output valid, channel, step_zero, step_one, step_two, step_three,
               step_four, step_five, step_six, step_seven, last,
        input  ready
    );
    modport sink (
        input  valid, channel, step_zero, step_one, step_two, step_three,
               step_four, step_five, step_six, step_seven, last,
        output ready
    );
endinterface

@@ design/apg_chord_prep.sv @@
module apg_chord_prep (
    input  apg_pkg::t_note  i_note_one,
    input  apg_pkg::t_note  i_note_two,
    input  apg_pkg::t_note  i_note_three,
    input  apg_pkg::t_note  i_note_four,
    input  apg_pkg::t_mode  i_mode,
    output apg_pkg::t_chord o_chord
);

    logic [3:0][6:0] slots;
    logic [3:0][6:0] played;
    logic [3:0][6:0] srt;
    logic [2:0]      cnt;
    logic [6:0]      tmp;

    assign slots = {i_note_four, i_note_three, i_note_two, i_note_one};

    // compact held notes in slot order
    always_comb begin
        played = '0;
        cnt    = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (slots[i] != 7'd0) begin
                played[cnt[1:0]] = slots[i];
                cnt              = cnt + 3'd1;
            end
        end
    end

    // five compare-exchange network, empty slots sink to the front
    always_comb begin
        srt = slots;
        tmp = '0;
        if (srt[0] > srt[1]) begin
            tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
        end
        if (srt[2] > srt[3]) begin
            tmp = srt[2]; srt[2] = srt[3]; srt[3] = tmp;
        end
        if (srt[0] > srt[2]) begin
            tmp = srt[0]; srt[0] = srt[2]; srt[2] = tmp;
        end
        if (srt[1] > srt[3]) begin
            tmp = srt[1]; srt[1] = srt[3]; srt[3] = tmp;
        end
        if (srt[1] > srt[2]) begin
            tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp;
        end
    end

    assign o_chord.played = played;
    assign o_chord.sorted = srt;
    assign o_chord.count  = cnt;
    assign o_chord.mode   = i_mode;

endmodule

@@ design/apg_pattern_gen.sv @@
module apg_pattern_gen (
    input  apg_pkg::t_chord    i_chord,
    input  apg_pkg::t_chan     i_chan,
    output apg_pkg::t_step_vec o_steps
);

    logic           silent;
    logic [1:0]     cnt_idx;
    logic [1:0]     mode_idx;
    apg_pkg::t_code code;
    logic [1:0]     sel;
    logic [6:0]     note;
    apg_pkg::t_step ofs;

    assign silent   = (i_chord.count == 3'd0) || (i_chord.mode == apg_pkg::MODE_SILENT);
    assign cnt_idx  = i_chord.count[1:0] - 2'd1;
    assign mode_idx = silent ? 2'd0 : i_chord.mode;

    always_comb begin
        o_steps = '0;
        code    = '0;
        sel     = '0;
        note    = '0;
        ofs     = '0;
        for (int st = 0; st < 8; st++) begin
            code = apg_pkg::PAT_TAB[cnt_idx][mode_idx][i_chan][st];
            // sorted list: held notes sit at the top, index minus count mod 4
            sel  = code[1:0] - i_chord.count[1:0];
            note = code[2] ? i_chord.sorted[sel] : i_chord.played[code[1:0]];
            case (code[5:4])
                apg_pkg::OFS_THIRD: ofs = apg_pkg::THIRD_STEP;
                apg_pkg::OFS_FIFTH: ofs = apg_pkg::FIFTH_STEP;
                default:            ofs = 8'd0;
            endcase
            if (!silent && code[7]) begin
                o_steps[st] = {1'b0, note} + ofs;
            end
        end
    end

endmodule

@@ design/arpeggio_pattern_generator.sv @@
// arpeggio pattern generator
// i_chord (sink): one word is a chord of four note slots, 0 marks an empty slot.
// o_pattern (source): four words per chord, channels 0 to 3 in order, each with
// eight pattern steps; last is set on the channel 3 word.
// i_cfg_we / i_cfg_wdata: writes arp_mode (0 to 2 pick a pattern set, 3 is
// silent); write only while no chord is in flight.
// a chord accepted is loaded into the chord register; when the output register is
// free, its channel 0 word enters the output register, then one word per
// cycle while o_pattern.ready is high.
// the single pattern unit produces one channel word per cycle from the
// registered chord while the output register is free.
// the next chord is taken in the cycle its predecessor's channel 3 word moves
// to the output register, so back-to-back chords stream without gaps.
// reset (synchronous, active low) empties the chord and output registers and
// sets arp_mode to 0.
// when the receiver stalls, the output word holds and the chord register holds,
// so i_chord.ready stays low until the channel 3 word can move to the output.
module arpeggio_pattern_generator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    apg_chord_if.sink         i_chord,
    apg_pattern_if.source     o_pattern,
    input  logic              i_cfg_we,
    input  apg_pkg::t_mode    i_cfg_wdata
);

    apg_pkg::t_mode     r_mode;
    apg_pkg::t_chord    r_chord;
    logic               r_chord_valid;
    apg_pkg::t_chan     r_chan;
    logic               r_out_valid;
    apg_pkg::t_chan     r_out_chan;
    apg_pkg::t_step_vec r_out_steps;
    logic               r_out_last;

    apg_pkg::t_chord    n_chord;
    apg_pkg::t_step_vec n_steps;
    logic               out_free;
    logic               take;
    logic               chord_done;
    logic               accept;

    apg_chord_prep u_prep (
        .i_note_one   (i_chord.slot_one_note),
        .i_note_two   (i_chord.slot_two_note),
        .i_note_three (i_chord.slot_three_note),
        .i_note_four  (i_chord.slot_four_note),
        .i_mode       (r_mode),
        .o_chord      (n_chord)
    );

    apg_pattern_gen u_gen (
        .i_chord (r_chord),
        .i_chan  (r_chan),
        .o_steps (n_steps)
    );

    assign out_free      = !r_out_valid || o_pattern.ready;
    assign take          = r_chord_valid && out_free;
    assign chord_done    = take && (r_chan == apg_pkg::LAST_CHAN);
    assign i_chord.ready = !r_chord_valid || chord_done;
    assign accept        = i_chord.valid && i_chord.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_chord_valid <= 1'b0;
            r_chan        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_chord_valid <= 1'b1;
            end else if (chord_done) begin
                r_chord_valid <= 1'b0;
            end
            if (take) begin
                r_chan <= r_chan + 2'd1;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_pattern.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chord <= n_chord;
        end
        if (take) begin
            r_out_chan  <= r_chan;
            r_out_steps <= n_steps;
            r_out_last  <= (r_chan == apg_pkg::LAST_CHAN);
        end
    end

    assign o_pattern.valid      = r_out_valid;
    assign o_pattern.channel    = r_out_chan;
    assign o_pattern.step_zero  = r_out_steps[0];
    assign o_pattern.step_one   = r_out_steps[1];
    assign o_pattern.step_two   = r_out_steps[2];
    assign o_pattern.step_three = r_out_steps[3];
    assign o_pattern.step_four  = r_out_steps[4];
    assign o_pattern.step_five  = r_out_steps[5];
    assign o_pattern.step_six   = r_out_steps[6];
    assign o_pattern.step_seven = r_out_steps[7];
    assign o_pattern.last       = r_out_last;

endmodule
